[hw/rtl/scig_pkg.sv]
// scig_pkg: shared types and constants of the stencil column index generator
// used by scig_front, scig_queue, scig_back and the top level
package scig_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int SIDE_W     = 9;
    localparam int COORD_W    = 8;
    localparam int AREA_W     = 18;
    localparam int FULL_W     = 28;
    localparam int NODE_W     = 24;
    localparam int COL_W      = 26;
    localparam int SLOT_W     = 5;
    localparam int NF_W       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIELDS    = 3'd4;

    localparam logic [1:0]        DIMS_2D      = 2'd2;
    localparam logic [SLOT_W-1:0] LAST_SLOT_2D = 5'd8;
    localparam logic [SLOT_W-1:0] LAST_SLOT_3D = 5'd26;

    typedef struct packed {
        logic              two_d;
        logic [SIDE_W-1:0] nx;
        logic [SIDE_W-1:0] ny;
        logic [SIDE_W-1:0] nz;
        logic [NF_W-1:0]   nf;
    } cfg_t;

    typedef struct packed {
        logic [FULL_W-1:0] center;
        logic [AREA_W-1:0] nxny;
        logic [SIDE_W-1:0] nx;
        logic              xm;
        logic              xp;
        logic              ym;
        logic              yp;
        logic              zm;
        logic              zp;
        logic              bad;
        logic              two_d;
    } desc_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s,
                                                     input logic [SIDE_W-1:0] max_side);
        logic [SIDE_W-1:0] r;
        if (s == '0) begin
            r = SIDE_W'(1);
        end else if (s > max_side) begin
            r = max_side;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

[hw/rtl/scig_front.sv]
// scig_front: accepts node beats, checks coordinates against the grid and
// computes the center node number; depends on scig_pkg
module scig_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  scig_pkg::cfg_t                 cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [scig_pkg::COORD_W-1:0]   s_node_x,
    input  logic [scig_pkg::COORD_W-1:0]   s_node_y,
    input  logic [scig_pkg::COORD_W-1:0]   s_node_z,
    input  logic                           q_full,
    output logic                           q_push,
    output scig_pkg::desc_t                q_data
);

    logic                              b_valid_reg, b_valid_next;
    logic [scig_pkg::COORD_W-1:0]      z_reg;
    logic [scig_pkg::AREA_W-1:0]       yx_reg;
    logic [scig_pkg::AREA_W-1:0]       nxny_reg;
    logic [scig_pkg::SIDE_W-1:0]       nx_reg;
    logic                              xm_reg, xp_reg, ym_reg, yp_reg, zm_reg, zp_reg;
    logic                              bad_reg, two_d_reg;

    logic [scig_pkg::COORD_W-1:0]      z_eff;
    logic [scig_pkg::AREA_W-2:0]       yprod;
    logic [scig_pkg::AREA_W-1:0]       yx_next;
    logic [scig_pkg::AREA_W-1:0]       nxny_next;
    logic [scig_pkg::COL_W-1:0]        zprod;
    logic                              bad_next;

    assign s_ready = !b_valid_reg || !q_full;
    assign q_push  = b_valid_reg && !q_full;

    always_comb begin
        z_eff     = cfg.two_d ? '0 : s_node_z;
        yprod     = s_node_y * cfg.nx;
        yx_next   = {1'b0, yprod} + {10'b0, s_node_x};
        nxny_next = cfg.nx * cfg.ny;
        bad_next  = ({1'b0, s_node_x} >= cfg.nx) || ({1'b0, s_node_y} >= cfg.ny) ||
                    (!cfg.two_d && ({1'b0, s_node_z} >= cfg.nz));
        if (s_ready) begin
            b_valid_next = s_valid;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            z_reg     <= z_eff;
            yx_reg    <= yx_next;
            nxny_reg  <= nxny_next;
            nx_reg    <= cfg.nx;
            xm_reg    <= s_node_x != '0;
            xp_reg    <= ({1'b0, s_node_x} + 9'd1) < cfg.nx;
            ym_reg    <= s_node_y != '0;
            yp_reg    <= ({1'b0, s_node_y} + 9'd1) < cfg.ny;
            zm_reg    <= z_eff != '0;
            zp_reg    <= ({1'b0, z_eff} + 9'd1) < cfg.nz;
            bad_reg   <= bad_next;
            two_d_reg <= cfg.two_d;
        end
    end

    always_comb begin
        zprod         = z_reg * nxny_reg;
        q_data.center = {2'b0, zprod} + {10'b0, yx_reg};
        q_data.nxny   = nxny_reg;
        q_data.nx     = nx_reg;
        q_data.xm     = xm_reg;
        q_data.xp     = xp_reg;
        q_data.ym     = ym_reg;
        q_data.yp     = yp_reg;
        q_data.zm     = zm_reg;
        q_data.zp     = zp_reg;
        q_data.bad    = bad_reg;
        q_data.two_d  = two_d_reg;
    end

endmodule

[hw/rtl/scig_queue.sv]
// scig_queue: two-entry queue of node descriptors between front and back
// depends on scig_pkg
module scig_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  scig_pkg::desc_t push_data,
    input  logic            pop,
    output scig_pkg::desc_t head,
    output logic            empty,
    output logic            full
);

    scig_pkg::desc_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign empty = count_reg == 2'd0;
    assign full  = count_reg == 2'd2;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/scig_back.sv]
// scig_back: walks the stencil slots of the head descriptor and forms node numbers and
// first columns, one beat a cycle unless the queue is empty or the output stalls; depends on scig_pkg
module scig_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scig_pkg::cfg_t                cfg,
    input  scig_pkg::desc_t               q_head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [scig_pkg::SLOT_W-1:0]   m_neighbor_slot,
    output logic [scig_pkg::NODE_W-1:0]   m_neighbor_node,
    output logic [scig_pkg::COL_W-1:0]    m_first_column,
    output logic                          m_bad_coordinate,
    output logic                          m_last
);

    logic [1:0]                     dx_reg, dx_next;
    logic [1:0]                     dy_reg, dy_next;
    logic [1:0]                     dz_reg, dz_next;
    logic [scig_pkg::SLOT_W-1:0]    k_reg, k_next;

    logic                           p1_valid_reg;
    logic [scig_pkg::SLOT_W-1:0]    p1_slot_reg;
    logic [scig_pkg::COL_W-1:0]     p1_node_reg;
    logic                           p1_bad_reg;
    logic                           p1_last_reg;

    logic                           m_valid_reg;
    logic [scig_pkg::SLOT_W-1:0]    m_slot_reg;
    logic [scig_pkg::NODE_W-1:0]    m_node_reg;
    logic [scig_pkg::COL_W-1:0]     m_col_reg;
    logic                           m_bad_reg;
    logic                           m_last_reg;

    logic                           en;
    logic                           step;
    logic                           last_slot;
    logic                           in_x, in_y, in_z, in_grid;
    logic [scig_pkg::FULL_W-1:0]    nx_w, nxny_w, x_term, y_term, z_term, sum;
    logic [scig_pkg::COL_W-1:0]     node_next;
    logic [scig_pkg::COL_W+scig_pkg::NF_W-1:0] col_prod;

    assign en    = !m_valid_reg || m_ready;
    assign step  = en && !q_empty;
    assign q_pop = step && last_slot;

    always_comb begin
        last_slot = k_reg == (q_head.two_d ? scig_pkg::LAST_SLOT_2D : scig_pkg::LAST_SLOT_3D);
        in_x = (dx_reg == 2'd0) ? q_head.xm : (dx_reg == 2'd2) ? q_head.xp : 1'b1;
        in_y = (dy_reg == 2'd0) ? q_head.ym : (dy_reg == 2'd2) ? q_head.yp : 1'b1;
        in_z = q_head.two_d ||
               ((dz_reg == 2'd0) ? q_head.zm : (dz_reg == 2'd2) ? q_head.zp : 1'b1);
        in_grid = !q_head.bad && in_x && in_y && in_z;

        nx_w   = {19'b0, q_head.nx};
        nxny_w = {10'b0, q_head.nxny};
        x_term = (dx_reg == 2'd0) ? '1 : (dx_reg == 2'd2) ? 28'd1 : '0;
        y_term = (dy_reg == 2'd0) ? (28'd0 - nx_w) : (dy_reg == 2'd2) ? nx_w : '0;
        if (q_head.two_d) begin
            z_term = '0;
        end else begin
            z_term = (dz_reg == 2'd0) ? (28'd0 - nxny_w) : (dz_reg == 2'd2) ? nxny_w : '0;
        end
        sum       = q_head.center + x_term + y_term + z_term;
        node_next = in_grid ? sum[scig_pkg::COL_W-1:0] : '0;

        dx_next = dx_reg;
        dy_next = dy_reg;
        dz_next = dz_reg;
        k_next  = k_reg;
        if (step) begin
            if (last_slot) begin
                dx_next = 2'd0;
                dy_next = 2'd0;
                dz_next = 2'd0;
                k_next  = '0;
            end else begin
                k_next = k_reg + 5'd1;
                if (dx_reg == 2'd2) begin
                    dx_next = 2'd0;
                    if (dy_reg == 2'd2) begin
                        dy_next = 2'd0;
                        dz_next = dz_reg + 2'd1;
                    end else begin
                        dy_next = dy_reg + 2'd1;
                    end
                end else begin
                    dx_next = dx_reg + 2'd1;
                end
            end
        end
        col_prod = p1_node_reg * cfg.nf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg       <= 2'd0;
            dy_reg       <= 2'd0;
            dz_reg       <= 2'd0;
            k_reg        <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
            k_reg  <= k_next;
            if (en) begin
                p1_valid_reg <= !q_empty;
                m_valid_reg  <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_slot_reg <= k_reg;
            p1_node_reg <= node_next;
            p1_bad_reg  <= q_head.bad;
            p1_last_reg <= last_slot;
            m_slot_reg  <= p1_slot_reg;
            m_node_reg  <= p1_node_reg[scig_pkg::NODE_W-1:0];
            m_col_reg   <= col_prod[scig_pkg::COL_W-1:0];
            m_bad_reg   <= p1_bad_reg;
            m_last_reg  <= p1_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_neighbor_slot  = m_slot_reg;
    assign m_neighbor_node  = m_node_reg;
    assign m_first_column   = m_col_reg;
    assign m_bad_coordinate = m_bad_reg;
    assign m_last           = m_last_reg;

`ifndef NO_ASSERTIONS
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |->
            (m_neighbor_slot == scig_pkg::LAST_SLOT_2D ||
             m_neighbor_slot == scig_pkg::LAST_SLOT_3D))
        else $error("last beat on a slot that does not end a row");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_coordinate |-> (m_neighbor_node == '0 && m_first_column == '0))
        else $error("bad coordinate beat with nonzero node or column");
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= scig_pkg::LAST_SLOT_3D)
        else $error("slot counter out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");
`endif

endmodule

[hw/rtl/stencil_column_index_generator.sv]
// Stencil column index generator: one node beat in, 9 (2D) or 27 (3D) neighbor beats out.
// First result path: front register, queue entry, back p1 register, back output register.
// The back slot sequencer gives one result beat per cycle unless the output stalls or the queue is empty.
// A two-entry descriptor queue lets the front take new nodes while results still drain.
// Reset (aresetn, synchronous, active low) sets grid_dims=3, sizes=1, fields=1, empties all.
// Depends on scig_pkg, scig_front, scig_queue, scig_back.
module stencil_column_index_generator #(
    parameter int MAX_GRID_SIDE = 256,
    parameter int MAX_FIELDS    = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [scig_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scig_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [scig_pkg::COORD_W-1:0]       s_node_x,
    input  logic [scig_pkg::COORD_W-1:0]       s_node_y,
    input  logic [scig_pkg::COORD_W-1:0]       s_node_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [scig_pkg::SLOT_W-1:0]        m_neighbor_slot,
    output logic [scig_pkg::NODE_W-1:0]        m_neighbor_node,
    output logic [scig_pkg::COL_W-1:0]         m_first_column,
    output logic                               m_bad_coordinate,
    output logic                               m_last
);

    localparam int MAX_SIDE_I = (MAX_GRID_SIDE > 511) ? 511 : MAX_GRID_SIDE;
    localparam logic [scig_pkg::SIDE_W-1:0] MAX_SIDE_C = scig_pkg::SIDE_W'(MAX_SIDE_I);
    localparam logic [scig_pkg::NF_W-1:0]   MAX_NF_C   = scig_pkg::NF_W'(MAX_FIELDS);

    logic [1:0]                    grid_dims_reg;
    logic [scig_pkg::SIDE_W-1:0]   size_x_reg;
    logic [scig_pkg::SIDE_W-1:0]   size_y_reg;
    logic [scig_pkg::SIDE_W-1:0]   size_z_reg;
    logic [2:0]                    fields_reg;

    scig_pkg::cfg_t                cfg;
    scig_pkg::desc_t               q_data;
    scig_pkg::desc_t               q_head;
    logic                          q_push, q_pop, q_empty, q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_dims_reg <= 2'd3;
            size_x_reg    <= 9'd1;
            size_y_reg    <= 9'd1;
            size_z_reg    <= 9'd1;
            fields_reg    <= 3'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                scig_pkg::REG_GRID_DIMS: grid_dims_reg <= cfg_data[1:0];
                scig_pkg::REG_SIZE_X:    size_x_reg    <= cfg_data;
                scig_pkg::REG_SIZE_Y:    size_y_reg    <= cfg_data;
                scig_pkg::REG_SIZE_Z:    size_z_reg    <= cfg_data;
                scig_pkg::REG_FIELDS:    fields_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.two_d = grid_dims_reg == scig_pkg::DIMS_2D;
        cfg.nx    = scig_pkg::clamp_side(size_x_reg, MAX_SIDE_C);
        cfg.ny    = scig_pkg::clamp_side(size_y_reg, MAX_SIDE_C);
        cfg.nz    = cfg.two_d ? 9'd1 : scig_pkg::clamp_side(size_z_reg, MAX_SIDE_C);
        if (fields_reg == 3'd0) begin
            cfg.nf = 4'd1;
        end else if ({1'b0, fields_reg} > MAX_NF_C) begin
            cfg.nf = MAX_NF_C;
        end else begin
            cfg.nf = {1'b0, fields_reg};
        end
    end

    scig_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_node_x (s_node_x),
        .s_node_y (s_node_y),
        .s_node_z (s_node_z),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    scig_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    scig_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .q_head           (q_head),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_slot  (m_neighbor_slot),
        .m_neighbor_node  (m_neighbor_node),
        .m_first_column   (m_first_column),
        .m_bad_coordinate (m_bad_coordinate),
        .m_last           (m_last)
    );

endmodule

[bench/stencil_column_index_generator_tb.sv]
// stencil_column_index_generator_tb: self-checking bench for the stencil column index generator
// a directed table and random grids feed node beats; each beat must match a predicted or flat row
// depends on scig_pkg and stencil_column_index_generator
module stencil_column_index_generator_tb;

    localparam int     SIDE_MAX     = 256;
    localparam int     FIELD_MAX    = 4;
    localparam int     REG_SPARE_LO = 5;
    localparam int     REG_SPARE_HI = 7;
    localparam int     PLAN_LEN     = 21;
    localparam int     PHASE_NODES  = 35;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     SETTLE       = 40;
    localparam int     MISS_SHOWN   = 10;
    localparam longint RUN_LIMIT    = 64'd4000000;

    localparam logic [1:0] DIMS_3D    = 2'd3;
    localparam logic [1:0] DIMS_ODD_0 = 2'd0;
    localparam logic [1:0] DIMS_ODD_1 = 2'd1;

    typedef struct packed {
        logic [scig_pkg::SLOT_W-1:0] slot;
        logic [scig_pkg::NODE_W-1:0] node;
        logic [scig_pkg::COL_W-1:0]  col;
        logic                        bad;
        logic                        last;
    } neighbor_beat_t;

    // wcfg loads the grid before the node; flat rows expect all nodes 0 with the given flag
    typedef struct packed {
        bit          wcfg;
        logic [1:0]  dims;
        logic [8:0]  sx;
        logic [8:0]  sy;
        logic [8:0]  sz;
        logic [2:0]  nf;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  z;
        bit          flat;
        bit          flat_bad;
    } plan_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [scig_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [scig_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [scig_pkg::COORD_W-1:0]   s_node_x = '0;
    logic [scig_pkg::COORD_W-1:0]   s_node_y = '0;
    logic [scig_pkg::COORD_W-1:0]   s_node_z = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [scig_pkg::SLOT_W-1:0]    m_neighbor_slot;
    logic [scig_pkg::NODE_W-1:0]    m_neighbor_node;
    logic [scig_pkg::COL_W-1:0]     m_first_column;
    logic                           m_bad_coordinate;
    logic                           m_last;

    // grid registers as the block should hold them
    logic [1:0] g_dims = DIMS_3D;
    logic [8:0] g_sx = 9'd1;
    logic [8:0] g_sy = 9'd1;
    logic [8:0] g_sz = 9'd1;
    logic [2:0] g_nf = 3'd1;

    neighbor_beat_t neighbor_due[$];

    int tx_idle_pct = 33;
    int rx_idle_pct = 48;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int misses = 0;
    int beats_seen = 0;
    int nodes_sent = 0;
    int grids_loaded = 0;

    plan_row_t plan [PLAN_LEN] = '{
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd1, 8'd0, 8'd0, 1'b1, 1'b1},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1},
        '{1'b1, DIMS_3D, 9'd4, 9'd3, 9'd5, 3'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd3, 8'd2, 8'd4, 1'b0, 1'b0},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd1, 8'd1, 8'd2, 1'b0, 1'b0},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd4, 8'd0, 8'd0, 1'b1, 1'b1},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd3, 8'd0, 1'b1, 1'b1},
        '{1'b0, DIMS_3D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd0, 8'd5, 1'b1, 1'b1},
        '{1'b1, scig_pkg::DIMS_2D, 9'd5, 9'd4, 9'd0, 3'd3, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0},
        '{1'b0, scig_pkg::DIMS_2D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd4, 8'd3, 8'd0, 1'b0, 1'b0},
        '{1'b0, scig_pkg::DIMS_2D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd2, 8'd1, 8'd7, 1'b0, 1'b0},
        '{1'b0, scig_pkg::DIMS_2D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd5, 8'd0, 8'd0, 1'b1, 1'b1},
        '{1'b1, DIMS_ODD_0, 9'd0, 9'd511, 9'd300, 3'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0},
        '{1'b0, DIMS_ODD_0, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd128, 8'd0, 1'b0, 1'b0},
        '{1'b0, DIMS_ODD_0, 9'd0, 9'd0, 9'd0, 3'd0, 8'd1, 8'd0, 8'd0, 1'b1, 1'b1},
        '{1'b1, DIMS_ODD_1, 9'd256, 9'd256, 9'd256, 3'd7, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0},
        '{1'b0, DIMS_ODD_1, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{1'b0, DIMS_ODD_1, 9'd0, 9'd0, 9'd0, 3'd0, 8'd128, 8'd1, 8'd254, 1'b0, 1'b0},
        '{1'b1, scig_pkg::DIMS_2D, 9'd256, 9'd256, 9'd1, 3'd4, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0},
        '{1'b0, scig_pkg::DIMS_2D, 9'd0, 9'd0, 9'd0, 3'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}
    };

    stencil_column_index_generator #(
        .MAX_GRID_SIDE(SIDE_MAX),
        .MAX_FIELDS   (FIELD_MAX)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_node_x        (s_node_x),
        .s_node_y        (s_node_y),
        .s_node_z        (s_node_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_neighbor_slot (m_neighbor_slot),
        .m_neighbor_node (m_neighbor_node),
        .m_first_column  (m_first_column),
        .m_bad_coordinate(m_bad_coordinate),
        .m_last          (m_last)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned fit_side(input logic [8:0] s);
        if (s == 9'd0) return 1;
        return (s > SIDE_MAX) ? SIDE_MAX : int'(s);
    endfunction

    // does coordinate c stay on the grid when moved by step code d (0,1,2 for -1,0,+1)
    function automatic bit near(input int unsigned c, input int unsigned d, input int unsigned n);
        case (d)
            0: return c != 0;
            2: return c + 1 < n;
            default: return 1'b1;
        endcase
    endfunction

    function automatic void set_reg(input logic [scig_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [scig_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            scig_pkg::REG_GRID_DIMS: g_dims = data[1:0];
            scig_pkg::REG_SIZE_X:    g_sx = data;
            scig_pkg::REG_SIZE_Y:    g_sy = data;
            scig_pkg::REG_SIZE_Z:    g_sz = data;
            scig_pkg::REG_FIELDS:    g_nf = data[2:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_stencil_row(input logic [7:0] x, input logic [7:0] y,
                                                input logic [7:0] z);
        bit             two_d;
        bit             bad;
        int unsigned    nx, ny, nz, nf, zc, slots, dx, dy, dz;
        longint unsigned node;
        neighbor_beat_t b;
        two_d = (g_dims == scig_pkg::DIMS_2D);
        nx = fit_side(g_sx);
        ny = fit_side(g_sy);
        nz = two_d ? 1 : fit_side(g_sz);
        nf = (g_nf == 3'd0) ? 1 : ((g_nf > FIELD_MAX) ? FIELD_MAX : int'(g_nf));
        zc = two_d ? 0 : int'(z);
        bad = (x >= nx) || (y >= ny) || (zc >= nz);
        slots = two_d ? 9 : 27;
        for (int unsigned k = 0; k < slots; k++) begin
            dx = k % 3;
            dy = (k / 3) % 3;
            dz = two_d ? 1 : k / 9;
            node = 0;
            if (!bad && near(x, dx, nx) && near(y, dy, ny) && near(zc, dz, nz)) begin
                node = longint'(zc + dz - 1) * nx * ny + longint'(y + dy - 1) * nx
                       + longint'(x + dx - 1);
            end
            b.slot = scig_pkg::SLOT_W'(k);
            b.node = scig_pkg::NODE_W'(node);
            b.col  = scig_pkg::COL_W'(node * nf);
            b.bad  = bad;
            b.last = (k == slots - 1);
            neighbor_due.push_back(b);
        end
    endfunction

    function automatic void push_flat_row(input bit bad);
        int unsigned    slots;
        neighbor_beat_t b;
        slots = (g_dims == scig_pkg::DIMS_2D) ? 9 : 27;
        for (int unsigned k = 0; k < slots; k++) begin
            b = '{scig_pkg::SLOT_W'(k), '0, '0, bad, k == slots - 1};
            neighbor_due.push_back(b);
        end
    endfunction

    function automatic logic [8:0] rand_side();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 9'd0;
        if (r == 1) return 9'($urandom_range(257, 511));
        if (r == 2) return 9'd256;
        if (r < 8) return 9'($urandom_range(1, 4));
        if (r < 12) return 9'($urandom_range(5, 32));
        return 9'($urandom_range(33, 255));
    endfunction

    function automatic logic [7:0] pick_coord(input int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'd0;
        if (r < 30) return 8'(n - 1);
        if (r < 90) return 8'($urandom_range(0, n - 1));
        return 8'($urandom);
    endfunction

    task automatic cfg_put(input logic [scig_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scig_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        set_reg(idx, data);
        @(negedge aclk);
    endtask

    // junk in the unused upper bits checks the register masks
    task automatic load_grid(input logic [1:0] dims, input logic [8:0] sx, input logic [8:0] sy,
                             input logic [8:0] sz, input logic [2:0] nf);
        cfg_put(scig_pkg::REG_GRID_DIMS, {7'($urandom), dims});
        cfg_put(scig_pkg::REG_SIZE_X, sx);
        cfg_put(scig_pkg::REG_SIZE_Y, sy);
        cfg_put(scig_pkg::REG_SIZE_Z, sz);
        cfg_put(scig_pkg::REG_FIELDS, {6'($urandom), nf});
        cfg_put(scig_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                scig_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        grids_loaded++;
    endtask

    task automatic load_random_grid();
        logic [1:0]  dims;
        int unsigned r;
        r = $urandom_range(0, 9);
        dims = (r < 4) ? scig_pkg::DIMS_2D : (r < 8) ? DIMS_3D :
               (r == 8) ? DIMS_ODD_0 : DIMS_ODD_1;
        load_grid(dims, rand_side(), rand_side(), rand_side(), 3'($urandom));
    endtask

    task automatic wait_drain();
        do @(negedge aclk); while (neighbor_due.size() != 0);
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic offer_node(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                              input bit flat, input bit flat_bad);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_node_x <= x;
        s_node_y <= y;
        s_node_z <= z;
        do @(posedge aclk); while (!s_ready);
        if (flat) push_flat_row(flat_bad);
        else predict_stencil_row(x, y, z);
        nodes_sent++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_beats
        neighbor_beat_t want;
        neighbor_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_neighbor_slot, m_neighbor_node, m_first_column, m_bad_coordinate, m_last};
            beats_seen++;
            if (neighbor_due.size() == 0) begin
                misses++;
                if (misses <= MISS_SHOWN)
                    $display("unexpected beat: slot %0d node %0d col %0d bad %b last %b",
                             got.slot, got.node, got.col, got.bad, got.last);
            end else begin
                want = neighbor_due.pop_front();
                if (got !== want) begin
                    misses++;
                    if (misses <= MISS_SHOWN)
                        $display("beat %0d mismatch: exp slot %0d node %0d col %0d ",
                                 beats_seen, want.slot, want.node, want.col,
                                 "bad %b last %b, got slot %0d node %0d col %0d ",
                                 want.bad, want.last, got.slot, got.node, got.col,
                                 "bad %b last %b", got.bad, got.last);
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d beats outstanding", neighbor_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].wcfg) begin
                s_valid <= 1'b0;
                wait_drain();
                load_grid(plan[i].dims, plan[i].sx, plan[i].sy, plan[i].sz, plan[i].nf);
            end
            offer_node(plan[i].x, plan[i].y, plan[i].z, plan[i].flat, plan[i].flat_bad);
        end

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct <= (mode == 0) ? 33 : (mode == 1) ? 48 : 0;
            rx_idle_pct <= (mode == 0) ? 48 : (mode == 1) ? 33 : 0;
            for (int phase = 0; phase < 4; phase++) begin
                s_valid <= 1'b0;
                wait_drain();
                load_random_grid();
                // long receiver stall while nodes keep coming
                if ((mode == 0 && phase == 1) || (mode == 1 && phase == 2))
                    hold_req <= hold_req + 1;
                for (int i = 0; i < PHASE_NODES; i++) begin
                    if (i == PHASE_NODES / 2) begin
                        s_valid <= 1'b0;
                        wait_drain();
                    end
                    offer_node(pick_coord(fit_side(g_sx)), pick_coord(fit_side(g_sy)),
                               pick_coord(fit_side(g_sz)), 1'b0, 1'b0);
                end
            end
        end

        s_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(negedge aclk);
        if (neighbor_due.size() != 0) begin
            misses++;
            $display("%0d expected beats never arrived", neighbor_due.size());
        end
        $display("%0d nodes over %0d grid settings, %0d neighbor beats checked, %0d mismatches",
                 nodes_sent, grids_loaded, beats_seen, misses);
        if (misses == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
